>>> design/usph_pkg.sv
// ----------------------------------------------------------------------------
// usph_pkg: shared types and constants of the UV sphere tessellator
// Widths, pipeline depths, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package usph_pkg;

  localparam int GRID_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int RADIUS_W    = 16;
  localparam int POS_W       = 17;
  localparam int IDX_W       = 12;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int MIN_COUNT   = 3;
  localparam int ANGLE_BITS  = 16;

  // Restoring divider for the grid angles.
  localparam int DIV_STEPS = ANGLE_BITS + 1;
  localparam int DIV_NUM_W = GRID_W + ANGLE_BITS;
  localparam int DIV_REM_W = COUNT_W;

  // CORDIC rotation.
  localparam int CORDIC_STEPS = 24;
  localparam int TRIG_W       = 34;
  localparam int Z_W          = 32;
  localparam int PROD_W       = 2 * TRIG_W;
  localparam int SCALE_W      = RADIUS_W + 1 + TRIG_W;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Entry stage, divider, CORDIC (prep, steps, quadrant restore), scaling.
  localparam int CORDIC_DEPTH = CORDIC_STEPS + 2;
  localparam int SCALE_DEPTH  = 4;
  localparam int PIPE_DEPTH   = 1 + DIV_STEPS + CORDIC_DEPTH + SCALE_DEPTH;

  localparam int POS_MAX = 65535;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 2'd2;

  // Triangle indices and flags that ride alongside the arithmetic.
  typedef struct packed {
    logic             out_of_range;
    logic             upper_valid;
    logic [IDX_W-1:0] upper_a;
    logic [IDX_W-1:0] upper_b;
    logic [IDX_W-1:0] upper_c;
    logic             lower_valid;
    logic [IDX_W-1:0] lower_a;
    logic [IDX_W-1:0] lower_b;
    logic [IDX_W-1:0] lower_c;
  } tri_sb_t;

  // Arctangent of 2^-i in 32-bit turn units.
  function automatic logic signed [Z_W-1:0] cordic_atan(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = 32'sh20000000;
      1:       a = 32'sh12E4051D;
      2:       a = 32'sh09FB385B;
      3:       a = 32'sh051111D4;
      4:       a = 32'sh028B0D43;
      5:       a = 32'sh0145D7E1;
      6:       a = 32'sh00A2F61E;
      7:       a = 32'sh00517C55;
      8:       a = 32'sh0028BE53;
      9:       a = 32'sh00145F2E;
      10:      a = 32'sh000A2F98;
      11:      a = 32'sh000517CC;
      12:      a = 32'sh00028BE6;
      13:      a = 32'sh000145F3;
      14:      a = 32'sh0000A2F9;
      15:      a = 32'sh0000517C;
      16:      a = 32'sh000028BE;
      17:      a = 32'sh0000145F;
      18:      a = 32'sh00000A2F;
      19:      a = 32'sh00000517;
      20:      a = 32'sh0000028B;
      21:      a = 32'sh00000145;
      22:      a = 32'sh000000A2;
      23:      a = 32'sh00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> design/uv_sphere_tessellator.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator: vertex position and triangle indices of a UV sphere
//
//   channel  dir  width  content
//   s_axis   in   16     grid_row [5:0], grid_column [11:6]
//   m_axis   out  128    position, two triangles, out_of_range flag
//   cfg      in   16     column_count, row_count, sphere_radius writes
//
// One grid point per clock while the output is not stalled; each beat passes
// the entry stage, the 17-stage angle divider, the 24-step CORDIC and scaling.
// The whole pipeline advances together and halts when the output beat is not
// taken, so a stall loses nothing. Reset clears the valid bits and loads the
// default counts (32 columns, 16 rows) and a radius of 1.0.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // grid_row [5:0], grid_column [11:6], zero [15:12]
  input  logic [15:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, upper_tri_valid, upper_corner_a/b/c,
  // lower_tri_valid, lower_corner_a/b/c, out_of_range, zero [127:126]
  output logic [127:0] m_axis_tdata
);

  localparam int D  = usph_pkg::PIPE_DEPTH;
  localparam int CW = usph_pkg::COUNT_W;
  localparam int GW = usph_pkg::GRID_W;
  localparam int IW = usph_pkg::IDX_W;
  localparam int AB = usph_pkg::ANGLE_BITS;

  logic [CW-1:0]                 col_cnt_q, row_cnt_q;
  logic [usph_pkg::RADIUS_W-1:0] radius_q;

  logic [CW-1:0] rows, cols;
  logic [GW-1:0] row, col, ncol;
  logic [IW+1:0] tl, tr, bl, br;
  usph_pkg::tri_sb_t sb_in;

  logic [usph_pkg::DIV_NUM_W-1:0] row_num_q, col_num_q;
  logic [usph_pkg::DIV_REM_W-1:0] row_den_q, col_den_q;
  logic [usph_pkg::DIV_STEPS-1:0] row_quo, col_quo;
  logic [AB-1:0] phi_ang, theta_ang;

  logic signed [usph_pkg::TRIG_W-1:0] cp, sp, ct, st;
  logic signed [usph_pkg::POS_W-1:0]  px, py, pz;

  logic              en;
  logic [D-1:0]      vld_q;
  usph_pkg::tri_sb_t sb_q [D];
  usph_pkg::tri_sb_t sb_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= CW'(32);
      row_cnt_q <= CW'(16);
      radius_q  <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        usph_pkg::REG_COLUMN_COUNT:  col_cnt_q <= cfg_data_i[CW-1:0];
        usph_pkg::REG_ROW_COUNT:     row_cnt_q <= cfg_data_i[CW-1:0];
        usph_pkg::REG_SPHERE_RADIUS: radius_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entry stage: clamp counts, range check and the triangle indices.
  always_comb begin
    if (row_cnt_q < CW'(usph_pkg::MIN_COUNT)) rows = CW'(usph_pkg::MIN_COUNT);
    else if (row_cnt_q > CW'(usph_pkg::MAX_ROWS)) rows = CW'(usph_pkg::MAX_ROWS);
    else rows = row_cnt_q;
    if (col_cnt_q < CW'(usph_pkg::MIN_COUNT)) cols = CW'(usph_pkg::MIN_COUNT);
    else if (col_cnt_q > CW'(usph_pkg::MAX_COLUMNS)) cols = CW'(usph_pkg::MAX_COLUMNS);
    else cols = col_cnt_q;

    row  = s_axis_tdata[GW-1:0];
    col  = s_axis_tdata[2*GW-1:GW];
    ncol = (CW'(col) + CW'(1) == cols) ? '0 : GW'(col + GW'(1));
    tl   = (IW+2)'(row) * (IW+2)'(cols) + (IW+2)'(col);
    tr   = (IW+2)'(row) * (IW+2)'(cols) + (IW+2)'(ncol);
    bl   = tl + (IW+2)'(cols);
    br   = tr + (IW+2)'(cols);

    sb_in = '0;
    if (CW'(row) >= rows || CW'(col) >= cols) begin
      sb_in.out_of_range = 1'b1;
    end else begin
      if (row != '0 && CW'(row) + CW'(1) < rows) begin
        sb_in.upper_valid = 1'b1;
        sb_in.upper_a     = tl[IW-1:0];
        sb_in.upper_b     = bl[IW-1:0];
        sb_in.upper_c     = tr[IW-1:0];
      end
      if (CW'(row) + CW'(2) < rows) begin
        sb_in.lower_valid = 1'b1;
        sb_in.lower_a     = tr[IW-1:0];
        sb_in.lower_b     = bl[IW-1:0];
        sb_in.lower_c     = br[IW-1:0];
      end
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[D-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0]   <= sb_in;
      for (int i = 1; i < D; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      // Rounded angles: row / (2 (rows - 1)) and column / columns of a turn.
      row_num_q <= {row, AB'(0)} + usph_pkg::DIV_NUM_W'(rows - CW'(1));
      row_den_q <= usph_pkg::DIV_REM_W'({rows - CW'(1), 1'b0});
      col_num_q <= {col, AB'(0)} + usph_pkg::DIV_NUM_W'(cols >> 1);
      col_den_q <= usph_pkg::DIV_REM_W'(cols);
    end
  end

  usph_div u_row_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (row_num_q),
    .den_i (row_den_q),
    .quo_o (row_quo)
  );

  usph_div u_col_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (col_num_q),
    .den_i (col_den_q),
    .quo_o (col_quo)
  );

  // Latitude is the quarter turn minus the row angle.
  assign phi_ang   = AB'(usph_pkg::DIV_STEPS'(1 << (AB - 2)) - row_quo);
  assign theta_ang = col_quo[AB-1:0];

  usph_cordic u_phi_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (phi_ang),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  usph_cordic u_theta_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (theta_ang),
    .cos_o   (ct),
    .sin_o   (st)
  );

  usph_scale u_scale (
    .clk_i       (clk_i),
    .en_i        (en),
    .radius_i    (radius_q),
    .cos_phi_i   (cp),
    .sin_phi_i   (sp),
    .cos_theta_i (ct),
    .sin_theta_i (st),
    .pos_x_o     (px),
    .pos_y_o     (py),
    .pos_z_o     (pz)
  );

  assign sb_out        = sb_q[D-1];
  assign m_axis_tvalid = vld_q[D-1];
  assign m_axis_tdata  = {
    2'b00,
    sb_out.out_of_range,
    sb_out.lower_c, sb_out.lower_b, sb_out.lower_a, sb_out.lower_valid,
    sb_out.upper_c, sb_out.upper_b, sb_out.upper_a, sb_out.upper_valid,
    sb_out.out_of_range ? usph_pkg::POS_W'(0) : pz,
    sb_out.out_of_range ? usph_pkg::POS_W'(0) : py,
    sb_out.out_of_range ? usph_pkg::POS_W'(0) : px
  };

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted beat did not enter the pipeline");

  a_oor_no_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sb_out.out_of_range |-> !sb_out.upper_valid && !sb_out.lower_valid)
    else $error("out of range point carries a triangle");

  a_tri_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && sb_in.upper_valid |-> row != '0)
    else $error("upper triangle on the first row");
`endif

endmodule

>>> design/usph_div.sv
// ----------------------------------------------------------------------------
// usph_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in DIV_STEPS bits.
// ----------------------------------------------------------------------------
module usph_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [usph_pkg::DIV_NUM_W-1:0]       num_i,
  input  logic [usph_pkg::DIV_REM_W-1:0]       den_i,
  output logic [usph_pkg::DIV_STEPS-1:0]       quo_o
);

  localparam int S  = usph_pkg::DIV_STEPS;
  localparam int RW = usph_pkg::DIV_REM_W;

  logic [RW-1:0] rem_q [S];
  logic [RW-1:0] den_q [S];
  logic [S-1:0]  num_q [S];
  logic [S-1:0]  quo_q [S];

  logic [RW-1:0] rem_in [S];
  logic [RW-1:0] den_in [S];
  logic [S-1:0]  num_in [S];
  logic [S-1:0]  quo_in [S];
  logic [RW:0]   trial  [S];

  always_comb begin
    for (int s = 0; s < S; s++) begin
      if (s == 0) begin
        rem_in[s] = RW'(num_i[usph_pkg::DIV_NUM_W-1:S]);
        den_in[s] = den_i;
        num_in[s] = num_i[S-1:0];
        quo_in[s] = '0;
      end else begin
        rem_in[s] = rem_q[s-1];
        den_in[s] = den_q[s-1];
        num_in[s] = num_q[s-1];
        quo_in[s] = quo_q[s-1];
      end
      trial[s] = {rem_in[s], num_in[s][S-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < S; s++) begin
        den_q[s] <= den_in[s];
        num_q[s] <= {num_in[s][S-2:0], 1'b0};
        if (trial[s] >= {1'b0, den_in[s]}) begin
          rem_q[s] <= RW'(trial[s] - {1'b0, den_in[s]});
          quo_q[s] <= {quo_in[s][S-2:0], 1'b1};
        end else begin
          rem_q[s] <= RW'(trial[s]);
          quo_q[s] <= {quo_in[s][S-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[S-1];

endmodule

>>> design/usph_cordic.sv
// ----------------------------------------------------------------------------
// usph_cordic: pipelined CORDIC cosine and sine
// Quadrant reduction, 24 rotation stages in Q2.30, quadrant restore.
// ----------------------------------------------------------------------------
module usph_cordic (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic [usph_pkg::ANGLE_BITS-1:0]         angle_i,
  output logic signed [usph_pkg::TRIG_W-1:0]      cos_o,
  output logic signed [usph_pkg::TRIG_W-1:0]      sin_o
);

  localparam int N  = usph_pkg::CORDIC_STEPS;
  localparam int TW = usph_pkg::TRIG_W;
  localparam int ZW = usph_pkg::Z_W;

  logic [ZW-1:0] turn, turn_ofs, resid;
  logic [1:0]    quad;

  logic signed [TW-1:0] x_q [N+1];
  logic signed [TW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic [1:0]           quad_q [N+1];
  logic signed [TW-1:0] cos_q, sin_q;

  always_comb begin
    turn     = {angle_i, (ZW - usph_pkg::ANGLE_BITS)'(0)};
    turn_ofs = turn + 32'h2000_0000;
    quad     = turn_ofs[ZW-1:ZW-2];
    resid    = turn - {quad, (ZW - 2)'(0)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= usph_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed(resid);
      quad_q[0] <= quad;
      for (int s = 0; s < N; s++) begin
        quad_q[s+1] <= quad_q[s];
        if (!z_q[s][ZW-1]) begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - usph_pkg::cordic_atan(s);
        end else begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + usph_pkg::cordic_atan(s);
        end
      end
      case (quad_q[N])
        2'd0: begin
          cos_q <= x_q[N];
          sin_q <= y_q[N];
        end
        2'd1: begin
          cos_q <= -y_q[N];
          sin_q <= x_q[N];
        end
        2'd2: begin
          cos_q <= -x_q[N];
          sin_q <= -y_q[N];
        end
        default: begin
          cos_q <= y_q[N];
          sin_q <= -x_q[N];
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

>>> design/usph_scale.sv
// ----------------------------------------------------------------------------
// usph_scale: trig products and radius scaling
// Four stages: products, Q2.30 rounding, radius multiply, rounding with
// saturation to signed Q8.8.
// ----------------------------------------------------------------------------
module usph_scale (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [usph_pkg::RADIUS_W-1:0]        radius_i,
  input  logic signed [usph_pkg::TRIG_W-1:0]   cos_phi_i,
  input  logic signed [usph_pkg::TRIG_W-1:0]   sin_phi_i,
  input  logic signed [usph_pkg::TRIG_W-1:0]   cos_theta_i,
  input  logic signed [usph_pkg::TRIG_W-1:0]   sin_theta_i,
  output logic signed [usph_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [usph_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [usph_pkg::POS_W-1:0]    pos_z_o
);

  localparam int TW = usph_pkg::TRIG_W;
  localparam int PW = usph_pkg::PROD_W;
  localparam int SW = usph_pkg::SCALE_W;
  localparam int VW = usph_pkg::POS_W;
  localparam int RADIUS_SW = usph_pkg::RADIUS_W + 1;

  logic signed [PW-1:0] px_q, pz_q;
  logic signed [TW-1:0] sy1_q;
  logic signed [TW-1:0] tx_q, ty_q, tz_q;
  logic signed [SW-1:0] mx_q, my_q, mz_q;
  logic signed [VW-1:0] x_q, y_q, z_q;

  logic signed [PW-1:0] rx, rz;
  logic signed [RADIUS_SW-1:0] rad;

  function automatic logic signed [VW-1:0] round_sat(input logic signed [SW-1:0] m);
    logic signed [SW-1:0] v;
    v = (m + SW'(1 <<< 29)) >>> 30;
    if (v > SW'(usph_pkg::POS_MAX)) begin
      return VW'(usph_pkg::POS_MAX);
    end else if (v < -SW'(usph_pkg::POS_MAX)) begin
      return -VW'(usph_pkg::POS_MAX);
    end
    return v[VW-1:0];
  endfunction

  always_comb begin
    rx  = (px_q + PW'(1 <<< 29)) >>> 30;
    rz  = (pz_q + PW'(1 <<< 29)) >>> 30;
    rad = $signed({1'b0, radius_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= PW'(cos_phi_i) * PW'(cos_theta_i);
      pz_q  <= PW'(cos_phi_i) * PW'(sin_theta_i);
      sy1_q <= sin_phi_i;
      tx_q  <= rx[TW-1:0];
      tz_q  <= rz[TW-1:0];
      ty_q  <= sy1_q;
      mx_q  <= SW'(rad) * SW'(tx_q);
      my_q  <= SW'(rad) * SW'(ty_q);
      mz_q  <= SW'(rad) * SW'(tz_q);
      x_q   <= round_sat(mx_q);
      y_q   <= round_sat(my_q);
      z_q   <= round_sat(mz_q);
    end
  end

  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign pos_z_o = z_q;

endmodule
